FILE: hdl/llc_pkg.sv
package llc_pkg;

	// window geometry: 7x7 start, three generations down to the origin
	localparam int LLC_GRID_RADIUS = 3;
	localparam int LLC_PAT_BITS    = 49;
	localparam int LLC_STATE_BITS  = 50;
	localparam int LLC_COUNT_BITS  = 46;
	localparam int LLC_WEIGHT_BITS = 6;

	localparam logic [LLC_WEIGHT_BITS-1:0] LLC_WEIGHT_RESET = 6'd1;

	// control token that travels with each item down the pipeline
	typedef struct packed {
		logic valid;
		logic clear;
		logic test;
		logic last;
	} llc_ctl_t;

endpackage

FILE: hdl/llc_life_gen.sv
module llc_life_gen #(
	parameter int RADIUS = llc_pkg::LLC_GRID_RADIUS
) (
	input  logic [(2*RADIUS+1)*(2*RADIUS+1)-1:0] grid,
	output logic [(2*RADIUS-1)*(2*RADIUS-1)-1:0] next
);
	import llc_pkg::*;

	localparam int SIDE  = 2 * RADIUS + 1;
	localparam int ISIDE = 2 * RADIUS - 1;

	// one life step, b3/s23, window shrinks by one cell on each side
	always_comb begin
		logic [3:0] n;
		logic       self_live;
		next = '0;
		for (int iy = 0; iy < ISIDE; iy++) begin
			for (int ix = 0; ix < ISIDE; ix++) begin
				n = 4'd0;
				for (int dy = 0; dy < 3; dy++) begin
					for (int dx = 0; dx < 3; dx++) begin
						if (dy != 1 || dx != 1) begin
							n = n + {3'b000, grid[(iy + dy) * SIDE + ix + dx]};
						end
					end
				end
				self_live = grid[(iy + 1) * SIDE + ix + 1];
				next[iy * ISIDE + ix] = (n == 4'd3) || (n == 4'd2 && self_live);
			end
		end
	end

endmodule

FILE: hdl/llc_enum.sv
module llc_enum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic                                begin_req,
	input  logic [llc_pkg::LLC_WEIGHT_BITS-1:0] weight,
	output llc_pkg::llc_ctl_t                   ctl,
	output logic [llc_pkg::LLC_PAT_BITS-1:0]    pattern
);
	import llc_pkg::*;

	logic [LLC_STATE_BITS-1:0] cur_q;
	logic                      enumerating_q;

	logic [LLC_STATE_BITS-1:0] first_pat;
	logic [LLC_STATE_BITS-1:0] low;
	logic [LLC_STATE_BITS-1:0] inc;
	logic [LLC_STATE_BITS-1:0] run;
	logic [LLC_STATE_BITS-1:0] fill;
	logic [LLC_STATE_BITS-1:0] nxt;
	logic [5:0]                run_len;

	// balanced adder tree over the lowest run of ones
	function automatic logic [5:0] popcount50(input logic [49:0] v);
		logic [1:0] l1 [26];
		logic [2:0] l2 [14];
		logic [3:0] l3 [8];
		logic [4:0] l4 [4];
		logic [5:0] l5 [2];
		for (int i = 0; i < 25; i++) begin
			l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		end
		l1[25] = 2'd0;
		for (int i = 0; i < 13; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		l2[13] = 3'd0;
		for (int i = 0; i < 7; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		l3[7] = 4'd0;
		for (int i = 0; i < 4; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
		end
		return l5[0] + l5[1];
	endfunction

	// first pattern of a weight: the lowest cells set, saturating at all ones
	always_comb begin
		for (int i = 0; i < LLC_STATE_BITS; i++) begin
			first_pat[i] = (6'(i) < weight);
		end
	end

	// next combination: add the lowest set bit, refill the run below
	assign low     = cur_q & (~cur_q + {{(LLC_STATE_BITS-1){1'b0}}, 1'b1});
	assign inc     = cur_q + low;
	assign run     = cur_q & ~inc;
	assign run_len = popcount50(run);

	always_comb begin
		for (int i = 0; i < LLC_STATE_BITS; i++) begin
			fill[i] = ({1'b0, 6'(i)} + 7'd2 <= {1'b0, run_len});
		end
	end

	assign nxt = inc | fill;

	// token for the pipeline
	always_comb begin
		ctl     = '0;
		pattern = cur_q[LLC_PAT_BITS-1:0];
		if (accept) begin
			if (begin_req) begin
				ctl.valid = 1'b1;
				ctl.clear = 1'b1;
			end else if (enumerating_q) begin
				ctl.valid = 1'b1;
				ctl.test  = ~cur_q[LLC_PAT_BITS];
				ctl.last  = cur_q[LLC_PAT_BITS] || (cur_q == '0) || nxt[LLC_PAT_BITS];
			end
		end
	end

	// pattern register and run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q         <= '0;
			enumerating_q <= 1'b0;
		end else if (accept) begin
			if (begin_req) begin
				cur_q         <= first_pat;
				enumerating_q <= 1'b1;
			end else if (enumerating_q) begin
				if (cur_q[LLC_PAT_BITS] || cur_q == '0) begin
					enumerating_q <= 1'b0;
				end else begin
					cur_q <= nxt;
					if (nxt[LLC_PAT_BITS]) begin
						enumerating_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

FILE: hdl/llc_accum.sv
module llc_accum (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  llc_pkg::llc_ctl_t                  ctl,
	input  logic [8:0]                         gen2,
	output logic                               hold,
	output logic [llc_pkg::LLC_COUNT_BITS-1:0] alive_count,
	output logic                               out_valid,
	input  logic                               out_stall
);
	import llc_pkg::*;

	logic [LLC_COUNT_BITS-1:0] count_q;
	logic [LLC_COUNT_BITS-1:0] sum;
	logic                      out_valid_q;
	logic [LLC_COUNT_BITS-1:0] alive_count_q;
	logic                      origin;
	logic                      load;

	// third generation: the origin cell alone
	llc_life_gen #(
		.RADIUS(1)
	) u_gen3 (
		.grid(gen2),
		.next(origin)
	);

	assign sum  = count_q + {{(LLC_COUNT_BITS-1){1'b0}}, ctl.test & origin};
	assign load = adv && ctl.valid && !ctl.clear && ctl.last;

	// a second final count cannot enter while the first still waits
	assign hold = ctl.valid && ctl.last && out_valid_q && out_stall;

	// running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv && ctl.valid) begin
			if (ctl.clear) begin
				count_q <= '0;
			end else begin
				count_q <= sum;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			alive_count_q <= sum;
		end
	end

	assign out_valid   = out_valid_q;
	assign alive_count = alive_count_q;

endmodule

FILE: hdl/life_light_cone_weight_census.sv
// result path: the last tick passes stages s1, s2 and s3, then the result register raises out_valid
// throughput: one item per cycle while in_stall is low, set by the next-combination step (50-bit add
//   and run-length count) on the pattern register
// reset: asynchronous active low; clears the pipeline control tokens, count, run flag and pattern,
//   weight register resets to one
module life_light_cone_weight_census (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                begin_req,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [llc_pkg::LLC_COUNT_BITS-1:0]  alive_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [llc_pkg::LLC_WEIGHT_BITS-1:0] cfg_data
);
	import llc_pkg::*;

	localparam int GEN1_BITS = (2 * LLC_GRID_RADIUS - 1) * (2 * LLC_GRID_RADIUS - 1);
	localparam int GEN2_BITS = (2 * LLC_GRID_RADIUS - 3) * (2 * LLC_GRID_RADIUS - 3);

	logic [LLC_WEIGHT_BITS-1:0] weight_q;
	logic                       accept;
	logic                       hold;
	logic                       adv;

	llc_ctl_t                   ctl_c;
	logic [LLC_PAT_BITS-1:0]    pattern_c;

	llc_ctl_t                   ctl_s1;
	llc_ctl_t                   ctl_s2;
	llc_ctl_t                   ctl_s3;
	logic [LLC_PAT_BITS-1:0]    pattern_s1;
	logic [GEN1_BITS-1:0]       gen1_c;
	logic [GEN1_BITS-1:0]       gen1_s2;
	logic [GEN2_BITS-1:0]       gen2_c;
	logic [GEN2_BITS-1:0]       gen2_s3;

	// weight register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= LLC_WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			weight_q <= cfg_data;
		end
	end

	// pipeline moves unless a final count is blocked at the end
	assign adv      = ~hold;
	assign in_stall = hold;
	assign accept   = in_valid && !in_stall;

	llc_enum u_enum (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.begin_req(begin_req),
		.weight   (weight_q),
		.ctl      (ctl_c),
		.pattern  (pattern_c)
	);

	llc_life_gen #(
		.RADIUS(LLC_GRID_RADIUS)
	) u_gen1 (
		.grid(pattern_s1),
		.next(gen1_c)
	);

	llc_life_gen #(
		.RADIUS(LLC_GRID_RADIUS - 1)
	) u_gen2 (
		.grid(gen1_s2),
		.next(gen2_c)
	);

	// control tokens of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_c;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// pattern and generation payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			pattern_s1 <= pattern_c;
			gen1_s2    <= gen1_c;
			gen2_s3    <= gen2_c;
		end
	end

	llc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl        (ctl_s3),
		.gen2       (gen2_s3),
		.hold       (hold),
		.alive_count(alive_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule

FILE: tb/life_light_cone_weight_census_tb.sv
module life_light_cone_weight_census_tb;

	import llc_pkg::*;

	localparam int LATENCY     = 3;
	localparam int RAND_ITEMS  = 650;
	localparam longint TIMEOUT_TU = 64'd5_000_000;

	localparam logic [63:0] PAT_LIMIT = 64'd1 << LLC_PAT_BITS;
	localparam logic [63:0] PAT_MASK  = (64'd1 << LLC_STATE_BITS) - 64'd1;

	// what begin_req carries
	localparam logic ITEM_TICK  = 1'b0;
	localparam logic ITEM_START = 1'b1;

	typedef enum logic {ROW_ITEM, ROW_WEIGHT} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		logic [LLC_WEIGHT_BITS-1:0] value;
		bit                        typed;
		bit                        has_res;
		logic [LLC_COUNT_BITS-1:0] res;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       begin_req = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [LLC_COUNT_BITS-1:0]  alive_count;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [LLC_WEIGHT_BITS-1:0] cfg_data = '0;

	// predictor state
	logic [LLC_WEIGHT_BITS-1:0] weight_r = LLC_WEIGHT_RESET;
	logic [63:0]                pat_r = '0;
	logic [LLC_COUNT_BITS-1:0]  tally_r = '0;
	bit                         run_r = 1'b0;

	logic [LLC_COUNT_BITS-1:0] expected_counts[$];
	stim_row_t                 plan[$];
	int errors = 0;
	int n_items = 0;
	bit no_gaps = 1'b0;

	life_light_cone_weight_census uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.begin_req  (begin_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.alive_count(alive_count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// cell (x,y) of a square grid of the given radius
	function automatic bit cell_at(logic [63:0] g, int r, int x, int y);
		int side;
		side = 2 * r + 1;
		return g[(y + r) * side + (x + r)];
	endfunction

	// one life generation, the grid shrinks by one cell on each side
	function automatic logic [63:0] life_gen(logic [63:0] g, int r);
		int inner;
		int side;
		int n;
		bit self;
		logic [63:0] nxt;
		inner = r - 1;
		side = 2 * inner + 1;
		nxt = '0;
		for (int y = -inner; y <= inner; y++) begin
			for (int x = -inner; x <= inner; x++) begin
				n = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++)
						if (dx != 0 || dy != 0)
							n += cell_at(g, r, x + dx, y + dy);
				self = cell_at(g, r, x, y);
				if (n == 3 || (n == 2 && self))
					nxt[(y + inner) * side + (x + inner)] = 1'b1;
			end
		end
		return nxt;
	endfunction

	function automatic bit origin_lives(logic [63:0] start);
		logic [63:0] g;
		g = life_gen(start & (PAT_LIMIT - 64'd1), LLC_GRID_RADIUS);
		g = life_gen(g, 2);
		g = life_gen(g, 1);
		return g[0];
	endfunction

	// advance the census by one item, returns the final count when a run ends
	function automatic void census_tick(input logic start, output bit emits,
			output logic [LLC_COUNT_BITS-1:0] count);
		logic [63:0] s;
		logic [63:0] low;
		logic [63:0] inc;
		logic [63:0] nxt;
		bit done;
		emits = 1'b0;
		count = '0;
		done = 1'b0;
		if (start) begin
			pat_r = ((64'd1 << weight_r) - 64'd1) & PAT_MASK;
			tally_r = '0;
			run_r = 1'b1;
			return;
		end
		if (!run_r)
			return;
		s = pat_r;
		if (s >= PAT_LIMIT) begin
			done = 1'b1;
		end else begin
			tally_r = tally_r + {{(LLC_COUNT_BITS-1){1'b0}}, origin_lives(s)};
			if (s == 64'd0) begin
				done = 1'b1;
			end else begin
				// next pattern of equal weight
				low = s & (~s + 64'd1);
				inc = s + low;
				nxt = inc + (((inc ^ s) / low) >> 2);
				pat_r = nxt & PAT_MASK;
				done = (nxt >= PAT_LIMIT);
			end
		end
		if (done) begin
			run_r = 1'b0;
			emits = 1'b1;
			count = tally_r;
		end
	endfunction

	function automatic int gap_draw();
		return no_gaps ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic stim_row_t mk_row(row_kind_t kind, logic [LLC_WEIGHT_BITS-1:0] value,
			bit typed, bit has_res, logic [LLC_COUNT_BITS-1:0] res);
		stim_row_t r;
		r.kind = kind;
		r.value = value;
		r.typed = typed;
		r.has_res = has_res;
		r.res = res;
		return r;
	endfunction

	// present one item, called at a rising edge, returns at the edge that takes it
	task automatic send_item(input logic start, input bit typed, input bit t_has,
			input logic [LLC_COUNT_BITS-1:0] t_val);
		int gap;
		bit ignored;
		bit emits;
		logic [LLC_COUNT_BITS-1:0] count;
		gap = gap_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		begin_req <= start;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		ignored = !start && !run_r;
		census_tick(start, emits, count);
		if (typed) begin
			if (t_has)
				expected_counts.push_back(t_val);
		end else if (emits) begin
			expected_counts.push_back(count);
		end
		if (!ignored)
			n_items++;
	endtask

	task automatic write_weight(input logic [LLC_WEIGHT_BITS-1:0] w);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		weight_r = w;
	endtask

	// stop sending and let the pipeline run dry
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// result side: random stalls, compare each taken count
	initial begin
		int n;
		logic [LLC_COUNT_BITS-1:0] want;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			n = gap_draw();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(negedge clk);
			while (!out_valid) @(negedge clk);
			if (expected_counts.size() == 0) begin
				$display("%0t unexpected count: expected none, actual %0d", $time, alive_count);
				errors++;
			end else begin
				want = expected_counts.pop_front();
				if (alive_count !== want) begin
					$display("%0t alive_count mismatch: expected %0d, actual %0d",
						$time, want, alive_count);
					errors++;
				end
			end
			@(posedge clk);
		end
	end

	initial begin
		#(TIMEOUT_TU);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int pick;
		int cap;
		int len;
		logic [LLC_WEIGHT_BITS-1:0] w;

		// directed rows
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 0, '0));   // tick while idle after reset
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_START), 0, 0, '0));  // weight one from reset
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_START), 0, 0, '0));  // restart mid run
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_START), 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 0, '0));
		plan.push_back(mk_row(ROW_WEIGHT, 6'd0, 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_START), 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 1, '0));   // empty pattern only
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 0, '0));   // idle again
		plan.push_back(mk_row(ROW_WEIGHT, 6'd49, 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_START), 0, 0, '0));
		plan.push_back(mk_row(ROW_WEIGHT, 6'd0, 0, 0, '0));          // change weight mid run
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 1, '0));   // full window dies at once
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_START), 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 1, '0));
		plan.push_back(mk_row(ROW_WEIGHT, 6'd63, 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_START), 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 1, '0));   // no pattern of this weight
		plan.push_back(mk_row(ROW_WEIGHT, 6'd50, 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_START), 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 1, 1, '0));
		plan.push_back(mk_row(ROW_WEIGHT, 6'd48, 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_START), 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 0, 0, '0));
		plan.push_back(mk_row(ROW_ITEM, 6'(ITEM_TICK), 0, 0, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WEIGHT) begin
				settle();
				write_weight(plan[i].value);
			end else begin
				send_item(plan[i].value[0], plan[i].typed, plan[i].has_res, plan[i].res);
			end
		end

		// random phases: mostly complete runs, some broken ones and noise
		n_items = 0;
		while (n_items < RAND_ITEMS) begin
			settle();
			no_gaps = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				case ($urandom_range(0, 5))
					0: w = 6'd0;
					1: w = 6'd49;
					2: w = 6'($urandom_range(50, 63));
					3: w = 6'd1;
					4: w = 6'd48;
					default: w = 6'($urandom_range(0, 63));
				endcase
				write_weight(w);
				send_item(ITEM_START, 1'b0, 1'b0, '0);
				// mid weights have far too many patterns, cut the run short
				cap = (w >= 2 && w <= 47) ? $urandom_range(1, 30) : 64;
				for (int k = 0; k < cap && run_r; k++)
					send_item(ITEM_TICK, 1'b0, 1'b0, '0);
			end else begin
				if ($urandom_range(0, 1) == 1)
					write_weight(6'($urandom_range(0, 63)));
				len = $urandom_range(1, 8);
				repeat (len) send_item(1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
			end
		end

		no_gaps = 1'b0;
		settle();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
hdl/llc_pkg.sv
hdl/llc_life_gen.sv
hdl/llc_enum.sv
hdl/llc_accum.sv
hdl/life_light_cone_weight_census.sv
tb/life_light_cone_weight_census_tb.sv
